/* src/qts_pkg.sv */
`timescale 1ns / 1ps
package qts_pkg;

   localparam int MinSpanDefault  = 66;
   localparam int FracBitsDefault = 16;
   localparam int SBits           = 30;
   localparam int CoefW           = 48;
   localparam int AccW            = 64;
   localparam int DivW            = 64;

   localparam logic signed [63:0] CoefLim = 64'sh0000_7FFF_FFFF_FFFF;
   localparam logic signed [63:0] AccLim  = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] OutLim  = 64'sh0000_0000_7FFF_FFFF;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_SHORT   = 2'd1,
      ST_NOSEG   = 2'd2
   } status_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_P_T2, S_P_V0T, S_P_VFT, S_P_A0T2, S_P_AFT2, S_P_B2, S_P_COMB, S_P_DONE,
      S_S_DIV, S_S_DIVW,
      S_S_HP, S_S_HV, S_S_HA,
      S_S_VDIV, S_S_VDIVW, S_S_ADIV1, S_S_ADIV1W, S_S_ADIV2, S_S_ADIV2W,
      S_OUT
   } state_type;

   function automatic logic signed [63:0] sat64(input logic signed [66:0] v,
                                                 input logic signed [63:0] lim);
      logic signed [66:0] l;
      l = 67'(lim);
      if (v > l) return lim;
      if (v < -l) return -lim;
      return v[63:0];
   endfunction

endpackage

/* src/qts_mul.sv */
`timescale 1ns / 1ps
// shared multiply: (|a|*|b|)>>sh, saturated to lim, signed; four 32x32 partial steps
module qts_mul (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic signed [63:0]  a,
   input  logic signed [63:0]  b,
   input  logic [5:0]          sh,
   input  logic signed [63:0]  lim,
   output logic                done,
   output logic signed [63:0]  result
);
   import qts_pkg::*;

   logic [63:0]  ma_ff, mb_ff, ma_in, mb_in;
   logic [127:0] prod_ff, prod_in;
   logic [2:0]   step_ff, step_in;
   logic         neg_ff, neg_in, busy_ff, busy_in, done_ff, done_in;
   logic [5:0]   sh_ff, sh_in;
   logic signed [63:0] lim_ff, lim_in, res_ff, res_in;
   logic [31:0]  pa, pb;
   logic [63:0]  pp;
   logic [127:0] shifted;

   always_comb begin
      pa = step_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      pb = step_ff[0] ? mb_ff[63:32] : mb_ff[31:0];
      pp = 64'(pa) * 64'(pb);
      shifted = prod_ff >> sh_ff;
      ma_in = ma_ff; mb_in = mb_ff; prod_in = prod_ff; step_in = step_ff;
      neg_in = neg_ff; busy_in = busy_ff; done_in = 1'b0; sh_in = sh_ff;
      lim_in = lim_ff; res_in = res_ff;
      if (start) begin
         ma_in = a[63] ? 64'(-a) : 64'(a);
         mb_in = b[63] ? 64'(-b) : 64'(b);
         neg_in = a[63] ^ b[63];
         sh_in = sh; lim_in = lim; prod_in = '0; step_in = '0; busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff == 3'd4) begin
            busy_in = 1'b0; done_in = 1'b1;
            if (shifted[127:63] != '0 || shifted[62:0] > 63'(lim_ff))
               res_in = neg_ff ? -lim_ff : lim_ff;
            else
               res_in = neg_ff ? -$signed(shifted[63:0]) : $signed(shifted[63:0]);
         end else begin
            prod_in = prod_ff + (128'(pp) << (7'(step_ff[1]) * 7'd32 + 7'(step_ff[0]) * 7'd32));
            step_in = step_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      ma_ff <= ma_in; mb_ff <= mb_in; prod_ff <= prod_in; step_ff <= step_in;
      neg_ff <= neg_in; sh_ff <= sh_in; lim_ff <= lim_in; res_ff <= res_in;
   end

   assign done = done_ff;
   assign result = res_ff;
endmodule

/* src/qts_div.sv */
`timescale 1ns / 1ps
// shared divider: unsigned num/den, one quotient bit per cycle
module qts_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   input  logic [31:0] den,
   output logic        done,
   output logic [63:0] quot
);
   import qts_pkg::*;

   logic [63:0] q_ff, q_in;
   logic [32:0] r_ff, r_in, trial;
   logic [6:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, done_ff, done_in;
   logic [31:0] d_ff, d_in;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      done_in = 1'b0; d_in = d_ff;
      trial = {r_ff[31:0], q_ff[63]};
      if (start) begin
         q_in = num; r_in = '0; cnt_in = '0; busy_in = 1'b1; d_in = den;
      end else if (busy_ff) begin
         if (trial >= 33'(d_ff)) begin
            r_in = trial - 33'(d_ff);
            q_in = {q_ff[62:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[62:0], 1'b0};
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'(DivW - 1)) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in; d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

/* src/quintic_trajectory_segment_top.sv */
`timescale 1ns / 1ps
// Plan beat: six passes through the shared 4-step multiplier, then the coefficients are
// combined. Sample beat: up to four passes through the 64-step divider and twelve Horner
// multiplies; short plans, samples with no segment and samples at or past the end go
// straight to the result state.
// One beat in flight; req_tready is low until the result beat is taken, so no request
// is accepted while rsp_tvalid is high.
// Synchronous reset clears the stored segment to zero and marks it invalid.
module quintic_trajectory_segment_top #(
   parameter int MIN_SPAN  = qts_pkg::MinSpanDefault,
   parameter int FRAC_BITS = qts_pkg::FracBitsDefault
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // tdata: start_pos, start_vel, start_acc, end_pos, end_vel, end_acc,
   //        span_time[30:0], elapsed_time[30:0], pad 2
   input  logic [255:0] req_tdata,
   // tuser: kind
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // tdata: status[1:0], position, velocity, acceleration, pad 6
   output logic [103:0] rsp_tdata
);
   import qts_pkg::*;

   state_type st_ff, st_in;
   logic signed [63:0] b_ff [6];
   logic signed [63:0] b_in [6];
   logic signed [31:0] fp_ff, fv_ff, fa_ff, fp_in, fv_in, fa_in;
   logic [31:0] span_ff, span_in;
   logic        valid_ff, valid_in;
   logic signed [31:0] p0_ff, v0_ff, a0_ff, pf_ff, vf_ff, af_ff;
   logic signed [31:0] p0_in, v0_in, a0_in, pf_in, vf_in, af_in;
   logic [30:0] tin_ff, tin_in, tt_ff, tt_in;
   logic signed [63:0] t2_ff, v0t_ff, vft_ff, a0t2_ff, aft2_ff, b2_ff;
   logic signed [63:0] t2_in, v0t_in, vft_in, a0t2_in, aft2_in, b2_in;
   logic signed [63:0] s_ff, s_in, h_ff, h_in, hv_ff, hv_in, ha_ff, ha_in;
   logic [2:0]  k_ff, k_in;
   logic        wait_ff, wait_in, vneg_ff, vneg_in;
   logic [1:0]  ost_ff, ost_in;
   logic signed [31:0] op_ff, ov_ff, oa_ff, op_in, ov_in, oa_in;
   logic        oval_ff, oval_in;

   logic        m_start, m_done, d_start, d_done;
   logic signed [63:0] m_a, m_b, m_lim, m_res;
   logic [5:0]  m_sh;
   logic [63:0] d_num, d_quot;
   logic [31:0] d_den;

   logic signed [66:0] dp, c3, c4, c5, hsum;
   logic signed [63:0] addk;
   logic [63:0] mg;
   logic signed [63:0] dv;

   qts_mul u_mul (.clock, .reset, .start(m_start), .a(m_a), .b(m_b), .sh(m_sh),
                  .lim(m_lim), .done(m_done), .result(m_res));
   qts_div u_div (.clock, .reset, .start(d_start), .num(d_num), .den(d_den),
                  .done(d_done), .quot(d_quot));

   // add term for Horner step k, selected by which polynomial
   function automatic logic signed [63:0] kterm(input logic [1:0] which,
                                               input logic [2:0] k,
                                               input logic signed [63:0] c);
      logic signed [63:0] r;
      r = c;
      if (which == 2'd1) r = c * 64'(k);
      else if (which == 2'd2) begin
         case (k)
            3'd4:    r = c * 64'sd12;
            3'd3:    r = c * 64'sd6;
            default: r = c * 64'sd2;
         endcase
      end
      return r;
   endfunction

   always_comb begin
      st_in = st_ff; b_in = b_ff; fp_in = fp_ff; fv_in = fv_ff; fa_in = fa_ff;
      span_in = span_ff; valid_in = valid_ff;
      p0_in = p0_ff; v0_in = v0_ff; a0_in = a0_ff; pf_in = pf_ff; vf_in = vf_ff;
      af_in = af_ff; tin_in = tin_ff; tt_in = tt_ff;
      t2_in = t2_ff; v0t_in = v0t_ff; vft_in = vft_ff; a0t2_in = a0t2_ff;
      aft2_in = aft2_ff; b2_in = b2_ff; s_in = s_ff; h_in = h_ff; hv_in = hv_ff;
      ha_in = ha_ff; k_in = k_ff; wait_in = wait_ff; vneg_in = vneg_ff;
      ost_in = ost_ff; op_in = op_ff; ov_in = ov_ff; oa_in = oa_ff; oval_in = oval_ff;
      m_start = 1'b0; m_a = '0; m_b = '0; m_sh = 6'(FRAC_BITS); m_lim = CoefLim;
      d_start = 1'b0; d_num = '0; d_den = span_ff;
      dp = 67'(pf_ff) - 67'(p0_ff);
      c3 = (67'sd20 * dp - 67'sd8 * 67'(vft_ff) - 67'sd12 * 67'(v0t_ff)
            - 67'sd3 * 67'(a0t2_ff) + 67'(aft2_ff)) / 2;
      c4 = (-67'sd30 * dp + 67'sd14 * 67'(vft_ff) + 67'sd16 * 67'(v0t_ff)
            + 67'sd3 * 67'(a0t2_ff) - 67'sd2 * 67'(aft2_ff)) / 2;
      c5 = (67'sd12 * dp - 67'sd6 * 67'(vft_ff) - 67'sd6 * 67'(v0t_ff)
            - 67'(a0t2_ff) + 67'(aft2_ff)) / 2;
      addk = '0; hsum = '0; mg = '0; dv = '0;
      if (oval_ff && rsp_tready) oval_in = 1'b0;

      unique case (st_ff)
         S_IDLE: begin
            if (req_tvalid && !oval_ff) begin
               p0_in = req_tdata[31:0];   v0_in = req_tdata[63:32];
               a0_in = req_tdata[95:64];  pf_in = req_tdata[127:96];
               vf_in = req_tdata[159:128]; af_in = req_tdata[191:160];
               tt_in = req_tdata[222:192]; tin_in = req_tdata[253:223];
               op_in = '0; ov_in = '0; oa_in = '0; ost_in = ST_OK;
               if (!req_tuser) begin
                  if (32'(req_tdata[222:192]) < 32'(MIN_SPAN)) begin
                     ost_in = ST_SHORT; st_in = S_OUT;
                  end else begin
                     m_start = 1'b1;
                     m_a = 64'(req_tdata[222:192]); m_b = 64'(req_tdata[222:192]);
                     st_in = S_P_T2;
                  end
               end else if (!valid_ff) begin
                  ost_in = ST_NOSEG; st_in = S_OUT;
               end else if (32'(req_tdata[253:223]) >= span_ff) begin
                  op_in = fp_ff; ov_in = fv_ff; oa_in = fa_ff; st_in = S_OUT;
               end else begin
                  d_start = 1'b1; d_num = 64'(req_tdata[253:223]) << SBits;
                  st_in = S_S_DIV;
               end
            end
         end
         S_P_T2: if (m_done) begin
            t2_in = m_res; m_start = 1'b1; m_a = 64'(v0_ff); m_b = 64'(tt_ff);
            st_in = S_P_V0T;
         end
         S_P_V0T: if (m_done) begin
            v0t_in = m_res; m_start = 1'b1; m_a = 64'(vf_ff); m_b = 64'(tt_ff);
            st_in = S_P_VFT;
         end
         S_P_VFT: if (m_done) begin
            vft_in = m_res; m_start = 1'b1; m_a = 64'(a0_ff); m_b = t2_ff;
            st_in = S_P_A0T2;
         end
         S_P_A0T2: if (m_done) begin
            a0t2_in = m_res; m_start = 1'b1; m_a = 64'(af_ff); m_b = t2_ff;
            st_in = S_P_AFT2;
         end
         S_P_AFT2: if (m_done) begin
            aft2_in = m_res; m_start = 1'b1; m_a = 64'(a0_ff); m_b = t2_ff;
            m_sh = 6'(FRAC_BITS + 1); st_in = S_P_B2;
         end
         S_P_B2: if (m_done) begin
            b2_in = m_res; st_in = S_P_COMB;
         end
         S_P_COMB: begin
            b_in[0] = 64'(p0_ff); b_in[1] = v0t_ff; b_in[2] = b2_ff;
            b_in[3] = sat64(c3, CoefLim); b_in[4] = sat64(c4, CoefLim);
            b_in[5] = sat64(c5, CoefLim);
            fp_in = pf_ff; fv_in = vf_ff; fa_in = af_ff; span_in = 32'(tt_ff);
            valid_in = 1'b1; st_in = S_P_DONE;
         end
         S_P_DONE: st_in = S_OUT;
         S_S_DIV: begin
            st_in = S_S_DIVW;
         end
         S_S_DIVW: if (d_done) begin
            s_in = $signed(d_quot);
            h_in = b_ff[5]; hv_in = b_ff[5] * 64'sd5; ha_in = b_ff[5] * 64'sd20;
            k_in = 3'd4; wait_in = 1'b0; st_in = S_S_HP;
         end
         S_S_HP, S_S_HV, S_S_HA: begin
            if (!wait_ff) begin
               m_start = 1'b1; m_b = s_ff; m_sh = 6'(SBits); m_lim = AccLim;
               m_a = (st_ff == S_S_HP) ? h_ff : (st_ff == S_S_HV) ? hv_ff : ha_ff;
               wait_in = 1'b1;
            end else if (m_done) begin
               wait_in = 1'b0;
               addk = kterm((st_ff == S_S_HP) ? 2'd0 : (st_ff == S_S_HV) ? 2'd1 : 2'd2,
                            k_ff, b_ff[k_ff]);
               hsum = 67'(m_res) + 67'(addk);
               if (st_ff == S_S_HP) h_in = sat64(hsum, AccLim);
               else if (st_ff == S_S_HV) hv_in = sat64(hsum, AccLim);
               else ha_in = sat64(hsum, AccLim);
               k_in = k_ff - 3'd1;
               if (st_ff == S_S_HP && k_ff == 3'd0) begin
                  k_in = 3'd4; st_in = S_S_HV;
               end else if (st_ff == S_S_HV && k_ff == 3'd1) begin
                  k_in = 3'd4; st_in = S_S_HA;
               end else if (st_ff == S_S_HA && k_ff == 3'd2) begin
                  st_in = S_S_VDIV;
               end
            end
         end
         S_S_VDIV, S_S_ADIV1, S_S_ADIV2: begin
            if (st_ff == S_S_VDIV) begin
               op_in = 32'(sat64(67'(h_ff), OutLim));
               dv = hv_ff;
            end else if (st_ff == S_S_ADIV1) dv = ha_ff;
            else dv = ha_ff;
            mg = dv[63] ? 64'(-dv) : 64'(dv);
            vneg_in = dv[63];
            if (mg >= (64'd1 << (63 - FRAC_BITS))) begin
               // overflow: quotient clamps to the limit
               if (st_ff == S_S_VDIV) begin
                  ov_in = dv[63] ? -32'sh7FFF_FFFF : 32'sh7FFF_FFFF; st_in = S_S_ADIV1;
               end else if (st_ff == S_S_ADIV1) begin
                  ha_in = dv[63] ? -AccLim : AccLim; st_in = S_S_ADIV2;
               end else begin
                  oa_in = dv[63] ? -32'sh7FFF_FFFF : 32'sh7FFF_FFFF; st_in = S_OUT;
               end
            end else begin
               d_start = 1'b1; d_num = mg << FRAC_BITS;
               st_in = (st_ff == S_S_VDIV) ? S_S_VDIVW
                     : (st_ff == S_S_ADIV1) ? S_S_ADIV1W : S_S_ADIV2W;
            end
         end
         S_S_VDIVW, S_S_ADIV1W, S_S_ADIV2W: if (d_done) begin
            if (st_ff == S_S_ADIV1W) begin
               mg = (d_quot > 64'(AccLim)) ? 64'(AccLim) : d_quot;
               ha_in = vneg_ff ? -$signed(mg) : $signed(mg);
               st_in = S_S_ADIV2;
            end else begin
               mg = (d_quot > 64'(OutLim)) ? 64'(OutLim) : d_quot;
               dv = vneg_ff ? -$signed(mg) : $signed(mg);
               if (st_ff == S_S_VDIVW) begin
                  ov_in = dv[31:0]; st_in = S_S_ADIV1;
               end else begin
                  oa_in = dv[31:0]; st_in = S_OUT;
               end
            end
         end
         S_OUT: begin
            oval_in = 1'b1; st_in = S_IDLE;
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE; valid_ff <= 1'b0; oval_ff <= 1'b0;
         for (int i = 0; i < 6; i++) b_ff[i] <= '0;
         fp_ff <= '0; fv_ff <= '0; fa_ff <= '0; span_ff <= '0; wait_ff <= 1'b0;
      end else begin
         st_ff <= st_in; valid_ff <= valid_in; oval_ff <= oval_in;
         b_ff <= b_in; fp_ff <= fp_in; fv_ff <= fv_in; fa_ff <= fa_in;
         span_ff <= span_in; wait_ff <= wait_in;
      end
      p0_ff <= p0_in; v0_ff <= v0_in; a0_ff <= a0_in; pf_ff <= pf_in;
      vf_ff <= vf_in; af_ff <= af_in; tin_ff <= tin_in; tt_ff <= tt_in;
      t2_ff <= t2_in; v0t_ff <= v0t_in; vft_ff <= vft_in; a0t2_ff <= a0t2_in;
      aft2_ff <= aft2_in; b2_ff <= b2_in; s_ff <= s_in; h_ff <= h_in;
      hv_ff <= hv_in; ha_ff <= ha_in; k_ff <= k_in; vneg_ff <= vneg_in;
      ost_ff <= ost_in; op_ff <= op_in; ov_ff <= ov_in; oa_ff <= oa_in;
   end

   assign req_tready = (st_ff == S_IDLE) && !oval_ff;
   assign rsp_tvalid = oval_ff;
   assign rsp_tdata  = {6'd0, oa_ff, ov_ff, op_ff, ost_ff};
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
   import qts_pkg::*;

   localparam int  MinSpan  = 66;
   localparam int  FracW    = 16;
   localparam int  FracS    = 30;
   localparam longint CoefMax = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint HornMax = 64'sh3FFF_FFFF_FFFF_FFFF;
   localparam longint OutMax  = 64'sh0000_0000_7FFF_FFFF;
   localparam int  RandItems = 1600;

   typedef enum bit {K_PLAN = 1'b0, K_SAMPLE = 1'b1} kind_type;

   typedef struct {
      kind_type          kind;
      logic signed [31:0] p0, v0, a0, pf, vf, af;
      logic [30:0]       span;
      logic [30:0]       elapsed;
   } traj_req_type;

   typedef struct {
      status_type         status;
      logic signed [31:0] pos, vel, acc;
   } traj_rsp_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [255:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [103:0] rsp_tdata;

   quintic_trajectory_segment_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   longint    seg_coef [6];
   longint    seg_end_pos, seg_end_vel, seg_end_acc;
   logic [31:0] seg_span;
   bit        seg_valid;

   traj_rsp_type expected_q[$];
   int        errors;
   int        burst_left;
   int        rx_hold;
   int        items_sent;

   initial begin
      forever #4 clock = ~clock;
   end

   function automatic longint clip(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic logic [63:0] magn(longint v);
      return v < 0 ? 64'(-v) : 64'(v);
   endfunction

   function automatic longint mul_shift(longint a, longint b, int sh, longint lim);
      logic [127:0] prod;
      logic [127:0] r;
      prod = {64'b0, magn(a)} * {64'b0, magn(b)};
      r = prod >> sh;
      if (r > 128'(lim)) r = 128'(lim);
      return ((a < 0) != (b < 0)) ? -longint'(r[63:0]) : longint'(r[63:0]);
   endfunction

   function automatic longint div_span(longint v, logic [31:0] span, longint lim);
      logic [63:0] m;
      logic [63:0] q;
      m = magn(v);
      if (m >= (64'd1 << (63 - FracW))) q = 64'(lim);
      else q = (m << FracW) / {32'b0, span};
      if (q > 64'(lim)) q = 64'(lim);
      return v < 0 ? -longint'(q) : longint'(q);
   endfunction

   function automatic longint horner(longint h, longint s, longint add);
      return clip(mul_shift(h, s, FracS, HornMax) + add, HornMax);
   endfunction

   task automatic trajectory_step(input traj_req_type r, output traj_rsp_type e);
      longint t, t2, v0t, vft, a0t2, aft2, dp, s, hp, hv, ha;
      e.status = ST_OK;
      e.pos = '0;
      e.vel = '0;
      e.acc = '0;
      if (r.kind == K_PLAN) begin
         if (r.span < MinSpan) begin
            e.status = ST_SHORT;
            return;
         end
         t    = longint'(r.span);
         t2   = mul_shift(t, t, FracW, CoefMax);
         v0t  = mul_shift(longint'(r.v0), t, FracW, CoefMax);
         vft  = mul_shift(longint'(r.vf), t, FracW, CoefMax);
         a0t2 = mul_shift(longint'(r.a0), t2, FracW, CoefMax);
         aft2 = mul_shift(longint'(r.af), t2, FracW, CoefMax);
         dp   = longint'(r.pf) - longint'(r.p0);
         seg_coef[0] = longint'(r.p0);
         seg_coef[1] = v0t;
         seg_coef[2] = mul_shift(longint'(r.a0), t2, FracW + 1, CoefMax);
         seg_coef[3] = clip((20 * dp - 8 * vft - 12 * v0t - 3 * a0t2 + aft2) / 2, CoefMax);
         seg_coef[4] = clip((-30 * dp + 14 * vft + 16 * v0t + 3 * a0t2 - 2 * aft2) / 2,
                            CoefMax);
         seg_coef[5] = clip((12 * dp - 6 * vft - 6 * v0t - a0t2 + aft2) / 2, CoefMax);
         seg_end_pos = longint'(r.pf);
         seg_end_vel = longint'(r.vf);
         seg_end_acc = longint'(r.af);
         seg_span    = {1'b0, r.span};
         seg_valid   = 1'b1;
      end else if (!seg_valid) begin
         e.status = ST_NOSEG;
      end else if ({1'b0, r.elapsed} >= seg_span) begin
         e.pos = seg_end_pos[31:0];
         e.vel = seg_end_vel[31:0];
         e.acc = seg_end_acc[31:0];
      end else begin
         s  = longint'(({33'b0, r.elapsed} << FracS) / {32'b0, seg_span});
         hp = seg_coef[5];
         for (int k = 4; k >= 0; k--) hp = horner(hp, s, seg_coef[k]);
         hv = 5 * seg_coef[5];
         for (int k = 4; k >= 1; k--) hv = horner(hv, s, k * seg_coef[k]);
         ha = 20 * seg_coef[5];
         ha = horner(ha, s, 12 * seg_coef[4]);
         ha = horner(ha, s, 6 * seg_coef[3]);
         ha = horner(ha, s, 2 * seg_coef[2]);
         e.pos = 32'(clip(hp, OutMax));
         e.vel = 32'(div_span(hv, seg_span, OutMax));
         e.acc = 32'(div_span(div_span(ha, seg_span, HornMax), seg_span, OutMax));
      end
   endtask

   task automatic send_beat(input traj_req_type r);
      traj_rsp_type e;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) begin
            req_tvalid <= 1'b0;
            repeat ($urandom_range(1, 25)) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser  <= r.kind;
      req_tdata  <= {2'b0, r.elapsed, r.span, r.af, r.vf, r.pf, r.a0, r.v0, r.p0};
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      trajectory_step(r, e);
      expected_q.push_back(e);
      items_sent++;
   endtask

   task automatic send_plan(input logic [31:0] p0, v0, a0, pf, vf, af,
                            input logic [30:0] span);
      traj_req_type r;
      r.kind = K_PLAN;
      r.p0 = p0; r.v0 = v0; r.a0 = a0; r.pf = pf; r.vf = vf; r.af = af;
      r.span = span;
      r.elapsed = 31'($urandom);
      send_beat(r);
   endtask

   task automatic send_sample(input logic [30:0] elapsed);
      traj_req_type r;
      r.kind = K_SAMPLE;
      r.p0 = $urandom; r.v0 = $urandom; r.a0 = $urandom;
      r.pf = $urandom; r.vf = $urandom; r.af = $urandom;
      r.span = 31'($urandom);
      r.elapsed = elapsed;
      send_beat(r);
   endtask

   function automatic logic [31:0] rand_value();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return 32'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
         2: return 32'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
         3: return 32'h8000_0000;
         default: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h0;
      endcase
   endfunction

   function automatic logic [30:0] rand_span();
      case ($urandom_range(0, 9))
         0: return 31'($urandom);
         1: return 31'($urandom_range(0, MinSpan - 1));
         2: return 31'($urandom_range(MinSpan, 1000));
         default: return 31'($urandom_range(MinSpan, 32'h0010_0000));
      endcase
   endfunction

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      wait (expected_q.size() == 0);
      @(posedge clock);
   endtask

   task automatic test_no_segment();
      send_sample(31'd0);
      send_sample(31'h7FFF_FFFF);
      send_plan(32'h1, 32'h1, 32'h1, 32'h2, 32'h2, 32'h2, 31'd0);
      send_plan(32'h1, 32'h1, 32'h1, 32'h2, 32'h2, 32'h2, 31'(MinSpan - 1));
      send_sample(31'd5);
   endtask

   task automatic test_extremes();
      send_plan(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 31'(MinSpan));
      send_sample(31'd0);
      send_sample(31'd1);
      send_sample(31'(MinSpan / 2));
      send_sample(31'(MinSpan - 1));
      send_sample(31'(MinSpan));
      send_plan(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_sample(31'd0);
      send_sample(31'h7FFF_FFFE);
      send_sample(31'h4000_0000);
      send_sample(31'h7FFF_FFFF);
      send_plan(32'h0001_0000, 32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h0, 31'h0002_0000);
      send_sample(31'h0001_0000);
      send_plan(32'hFFFF_0000, 32'h1234, 32'h0, 32'h5, 32'h6, 32'h7, 31'(MinSpan - 1));
      send_sample(31'h0000_8000);
      send_sample(31'h0003_0000);
      wait_drained();
   endtask

   task automatic test_backpressure();
      rx_hold = 400;
      repeat (6) send_sample(31'($urandom_range(0, 32'h0002_0000)));
      send_plan(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                rand_value(), 31'h0001_0000);
      wait_drained();
   endtask

   task automatic test_random();
      logic [30:0] cur_span;
      cur_span = 31'h0002_0000;
      while (items_sent < RandItems) begin
         if ($urandom_range(0, 3) == 0) begin
            send_plan(rand_value(), rand_value(), rand_value(), rand_value(), rand_value(),
                      rand_value(), rand_span());
            if (seg_valid) cur_span = seg_span[30:0];
         end else if ($urandom_range(0, 19) == 0) begin
            send_sample(31'($urandom));
         end else begin
            send_sample(31'($urandom_range(0, 32'(cur_span) + 32'(cur_span) / 8)));
         end
         if ($urandom_range(0, 199) == 0) wait_drained();
      end
      wait_drained();
   endtask

   initial begin
      traj_rsp_type e;
      traj_rsp_type got;
      bit fire;
      forever begin
         @(negedge clock);
         fire = rsp_tvalid && rsp_tready;
         got.status = status_type'(rsp_tdata[1:0]);
         got.pos = rsp_tdata[33:2];
         got.vel = rsp_tdata[65:34];
         got.acc = rsp_tdata[97:66];
         @(posedge clock);
         if (fire) begin
            if (expected_q.size() == 0) begin
               $error("unexpected result beat status=%0d", got.status);
               errors++;
            end else begin
               e = expected_q.pop_front();
               if (got.status !== e.status) begin
                  $error("status: expected %0d, actual %0d", e.status, got.status);
                  errors++;
               end
               if (got.pos !== e.pos) begin
                  $error("position: expected %0d, actual %0d", e.pos, got.pos);
                  errors++;
               end
               if (got.vel !== e.vel) begin
                  $error("velocity: expected %0d, actual %0d", e.vel, got.vel);
                  errors++;
               end
               if (got.acc !== e.acc) begin
                  $error("acceleration: expected %0d, actual %0d", e.acc, got.acc);
                  errors++;
               end
            end
         end
      end
   end

   initial begin
      bit choppy;
      choppy = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 63) == 0) choppy = !choppy;
         if (rx_hold > 0) begin
            rx_hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= choppy ? ($urandom_range(0, 2) == 0) : 1'b1;
         end
      end
   end

   initial begin
      #30ms;
      $display("== FAIL ==");
      $finish;
   end

   initial begin
      errors = 0;
      burst_left = 0;
      rx_hold = 0;
      items_sent = 0;
      seg_valid = 1'b0;
      seg_span = '0;
      seg_end_pos = 0;
      seg_end_vel = 0;
      seg_end_acc = 0;
      foreach (seg_coef[k]) seg_coef[k] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_no_segment();
      test_extremes();
      test_backpressure();
      test_random();
      repeat (400) @(posedge clock);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
